// ===== sv/utf8_dvb_control_code_stripper_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the control code stripper
// Shared clocking and reset conventions for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UTF8_DVB_CONTROL_CODE_STRIPPER_UNIT_ASSERT_SVH
`define UTF8_DVB_CONTROL_CODE_STRIPPER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8DCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8DCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/u8dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dcs_pkg
// Shared constants, types and helpers for the UTF-8 control code stripper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8dcs_pkg;

    // Longest accepted UTF-8 sequence and the number of bytes held before the last one.
    localparam int MAX_SEQ_BYTES = 6;
    localparam int HOLD_DEPTH    = MAX_SEQ_BYTES - 1;
    localparam int CNT_W         = 3;
    localparam int IDX_W         = $clog2(HOLD_DEPTH);
    localparam int CODE_W        = 31;

    // Byte values and masks.
    localparam logic [7:0] SELECTOR_BYTE = 8'h15;
    localparam logic [7:0] NEWLINE_BYTE  = 8'h0A;
    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [7:0] CONT_MASK     = 8'hC0;
    localparam logic [7:0] CONT_TAG      = 8'h80;
    localparam logic [7:0] PAYLOAD_MASK  = 8'h3F;

    // Control code points.
    localparam logic [CODE_W-1:0] CODE_EMPH_ON  = 31'h0000_E086;
    localparam logic [CODE_W-1:0] CODE_EMPH_OFF = 31'h0000_E087;
    localparam logic [CODE_W-1:0] CODE_NEWLINE  = 31'h0000_E08A;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic advance;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic plan_nonempty;
        logic last_entry;
    } dp_status_t;

    // Decoded lead byte: continuation bytes expected and payload mask.
    typedef struct packed {
        logic [CNT_W-1:0] need;
        logic [7:0]       mask;
    } lead_info_t;

    function automatic lead_info_t decode_lead(input logic [7:0] c);
        lead_info_t info;
        info.need = '0;
        info.mask = '0;
        if (c[7:5] == 3'b110) begin
            info.need = 3'd1;
            info.mask = 8'h1F;
        end
        else if (c[7:4] == 4'b1110) begin
            info.need = 3'd2;
            info.mask = 8'h0F;
        end
        else if (c[7:3] == 5'b11110) begin
            info.need = 3'd3;
            info.mask = 8'h07;
        end
        else if (c[7:2] == 6'b111110) begin
            info.need = 3'd4;
            info.mask = 8'h03;
        end
        else if (c[7:1] == 7'b1111110) begin
            info.need = 3'd5;
            info.mask = 8'h01;
        end
        return info;
    endfunction

endpackage

// ===== sv/u8dcs_in_if.sv =====
// ----------------------------------------------------------------------------
// u8dcs_in_if
// Input channel: one string byte per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8dcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_of_string;

    modport source (output valid, output in_byte, output first_of_string, input ready);
    modport sink   (input valid, input in_byte, input first_of_string, output ready);
endinterface

// ===== sv/u8dcs_out_if.sv =====
// ----------------------------------------------------------------------------
// u8dcs_out_if
// Output channel: one cleaned byte or end marker per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8dcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       end_of_string;
    logic       last_of_run;

    modport source (output valid, output out_byte, output byte_present,
                    output end_of_string, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input byte_present,
                    input end_of_string, input last_of_run, output ready);
endinterface

// ===== sv/utf8_dvb_control_code_stripper_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_dvb_control_code_stripper_unit
// Strips DVB control codes from a UTF-8 byte string, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one string byte per transaction with first_of_string marking
//   the head of a string. out_ch carries the cleaned bytes; a transaction with
//   byte_present low and end_of_string high is the terminator marker, and
//   last_of_run flags the final result caused by one input byte.
// Timing:
//   Results appear the cycle after the input transaction. A byte that causes
//   no result leaves the input free for the next byte. The k results of one
//   byte (k up to 6, the flushed held bytes of a malformed or completed
//   sequence plus one) drain one entry per cycle while out_ch.ready is high,
//   and the next input byte is taken in the cycle the last result is taken.
// Reset:
//   rst_n clears the pending sequence and the result list; the held bytes are
//   rewritten before they are ever read.
// Stall:
//   While a result is pending and out_ch.ready is low, the result holds and
//   in_ch.ready is low, so no input is taken until the last result leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_dvb_control_code_stripper_unit (
    input  logic         clk,
    input  logic         rst_n,
    u8dcs_in_if.sink     in_ch,
    u8dcs_out_if.source  out_ch
);
    import u8dcs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Handshake sequencing.
    u8dcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Decoder and result list.
    u8dcs_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_byte         (in_ch.in_byte),
        .first_of_string (in_ch.first_of_string),
        .out_byte        (out_ch.out_byte),
        .byte_present    (out_ch.byte_present),
        .end_of_string   (out_ch.end_of_string),
        .last_of_run     (out_ch.last_of_run)
    );

endmodule

// ===== sv/u8dcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// u8dcs_ctrl
// Controller: takes input transactions and steps through the result list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8dcs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  u8dcs_pkg::dp_status_t status,
    output u8dcs_pkg::dp_cmd_t    cmd
);
    import u8dcs_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. A new byte is taken when idle or as the last result leaves.
    always_comb
    begin
        state_next  = state_reg;
        out_valid   = 1'b0;
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && status.plan_nonempty)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.advance = out_ready;
                in_ready    = out_ready && status.last_entry;
                cmd.load    = in_valid && in_ready;
                if (out_ready && status.last_entry)
                begin
                    if (in_valid && status.plan_nonempty)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/u8dcs_datapath.sv =====
// ----------------------------------------------------------------------------
// u8dcs_datapath
// Sequence decoder state, result list registers and output selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8dcs_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8dcs_pkg::dp_cmd_t    cmd,
    output u8dcs_pkg::dp_status_t status,
    input  logic [7:0]            in_byte,
    input  logic                  first_of_string,
    output logic [7:0]            out_byte,
    output logic                  byte_present,
    output logic                  end_of_string,
    output logic                  last_of_run
);
    import u8dcs_pkg::*;

    // Decoder state.
    logic [7:0]        held_reg [HOLD_DEPTH];
    logic [7:0]        held_next [HOLD_DEPTH];
    logic [CNT_W-1:0]  held_cnt_reg, held_cnt_next;
    logic [CNT_W-1:0]  need_reg, need_next;
    logic [CODE_W-1:0] accum_reg, accum_next;

    // Result list: flushed bytes followed by an optional final entry.
    logic [7:0]        snap_reg [HOLD_DEPTH];
    logic [CNT_W-1:0]  flush_cnt_reg, flush_cnt_next;
    logic              fin_valid_reg, fin_valid_next;
    logic [7:0]        fin_byte_reg, fin_byte_next;
    logic              fin_present_reg, fin_present_next;
    logic              fin_end_reg, fin_end_next;
    logic [CNT_W-1:0]  idx_reg;

    // Working values.
    logic [CNT_W-1:0]  held_cnt_eff;
    logic [CNT_W-1:0]  need_eff;
    logic [CODE_W-1:0] accum_eff;
    logic [CODE_W-1:0] accum_cont;
    logic [CNT_W-1:0]  need_dec;
    logic              do_fresh;
    lead_info_t        lead;
    logic [CNT_W-1:0]  total_cnt;

    assign lead = decode_lead(in_byte);

    // Decode the incoming byte against the pending sequence.
    always_comb
    begin
        held_cnt_eff     = first_of_string ? '0 : held_cnt_reg;
        need_eff         = first_of_string ? '0 : need_reg;
        accum_eff        = first_of_string ? '0 : accum_reg;
        accum_cont       = {accum_eff[CODE_W-7:0], in_byte[5:0] & PAYLOAD_MASK[5:0]};
        need_dec         = need_eff - 1'b1;
        held_next        = held_reg;
        held_cnt_next    = held_cnt_eff;
        need_next        = need_eff;
        accum_next       = accum_eff;
        flush_cnt_next   = '0;
        fin_valid_next   = 1'b0;
        fin_byte_next    = in_byte;
        fin_present_next = 1'b1;
        fin_end_next     = 1'b0;
        do_fresh         = 1'b0;

        if (first_of_string && (in_byte == SELECTOR_BYTE))
        begin
            // Selector byte at the head of a string is dropped.
        end
        else if (need_eff == '0)
        begin
            do_fresh = 1'b1;
        end
        else if ((in_byte & CONT_MASK) == CONT_TAG)
        begin
            if (need_dec != '0)
            begin
                need_next  = need_dec;
                accum_next = accum_cont;
                if (held_cnt_eff < CNT_W'(HOLD_DEPTH))
                begin
                    held_next[held_cnt_eff[IDX_W-1:0]] = in_byte;
                    held_cnt_next = held_cnt_eff + 1'b1;
                end
            end
            else
            begin
                held_cnt_next = '0;
                need_next     = '0;
                accum_next    = '0;
                if ((accum_cont == CODE_EMPH_ON) || (accum_cont == CODE_EMPH_OFF))
                begin
                    // Emphasis control codes vanish.
                end
                else if (accum_cont == CODE_NEWLINE)
                begin
                    fin_valid_next = 1'b1;
                    fin_byte_next  = NEWLINE_BYTE;
                end
                else
                begin
                    flush_cnt_next = held_cnt_eff;
                    fin_valid_next = 1'b1;
                end
            end
        end
        else
        begin
            // Malformed sequence: flush what is held, then restart on this byte.
            flush_cnt_next = held_cnt_eff;
            held_cnt_next  = '0;
            need_next      = '0;
            accum_next     = '0;
            do_fresh       = 1'b1;
        end

        // Fresh start on a byte outside any sequence.
        if (do_fresh)
        begin
            if (in_byte == '0)
            begin
                fin_valid_next   = 1'b1;
                fin_present_next = 1'b0;
                fin_end_next     = 1'b1;
            end
            else if (in_byte < ASCII_LIMIT)
            begin
                fin_valid_next = 1'b1;
            end
            else if ((lead.need != '0) && (lead.need <= CNT_W'(HOLD_DEPTH)))
            begin
                held_next[0]  = in_byte;
                held_cnt_next = CNT_W'(1);
                need_next     = lead.need;
                accum_next    = CODE_W'(in_byte & lead.mask);
            end
            else
            begin
                fin_valid_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg  <= '0;
            need_reg      <= '0;
            accum_reg     <= '0;
            flush_cnt_reg <= '0;
            fin_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (cmd.load)
        begin
            held_cnt_reg  <= held_cnt_next;
            need_reg      <= need_next;
            accum_reg     <= accum_next;
            flush_cnt_reg <= flush_cnt_next;
            fin_valid_reg <= fin_valid_next;
            idx_reg       <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            held_reg        <= held_next;
            snap_reg        <= held_reg;
            fin_byte_reg    <= fin_byte_next;
            fin_present_reg <= fin_present_next;
            fin_end_reg     <= fin_end_next;
        end
    end

    // Status and result selection.
    assign total_cnt            = flush_cnt_reg + CNT_W'(fin_valid_reg);
    assign status.plan_nonempty = (flush_cnt_next != '0) || fin_valid_next;
    assign status.last_entry    = (idx_reg == (total_cnt - 1'b1));

    always_comb
    begin
        if (idx_reg < flush_cnt_reg)
        begin
            out_byte      = snap_reg[idx_reg[IDX_W-1:0]];
            byte_present  = 1'b1;
            end_of_string = 1'b0;
        end
        else
        begin
            out_byte      = fin_byte_reg;
            byte_present  = fin_present_reg;
            end_of_string = fin_end_reg;
        end
        last_of_run = status.last_entry;
    end

endmodule

// ===== sv/u8dcs_checker.sv =====
// ----------------------------------------------------------------------------
// u8dcs_checker
// Port level checks for the control code stripper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_dvb_control_code_stripper_unit_assert.svh"

module u8dcs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic byte_present,
    input logic end_of_string,
    input logic last_of_run
);

    // A pending result stays offered until taken.
    `U8DCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // A new byte is only taken as the last pending result leaves.
    `U8DCS_ASSERT_SAME(a_in_after_last, in_valid && in_ready, !out_valid || (out_ready && last_of_run), "input taken with results pending")

    // The terminator marker always closes its run.
    `U8DCS_ASSERT_SAME(a_end_is_last, out_valid && end_of_string, last_of_run, "end marker not last of run")

    // A result without a byte is only the terminator marker.
    `U8DCS_ASSERT_SAME(a_bare_is_end, out_valid && !byte_present, end_of_string, "bare result without end marker")

endmodule

bind utf8_dvb_control_code_stripper_unit u8dcs_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .byte_present  (out_ch.byte_present),
    .end_of_string (out_ch.end_of_string),
    .last_of_run   (out_ch.last_of_run)
);

// ===== tb/sv/utf8_dvb_control_code_stripper_unit_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_dvb_control_code_stripper_unit_tb
// Self-checking bench for the UTF-8 control code stripper. A queue of string
// bytes, directed and then random, feeds a clocked driver. Each accepted byte
// runs through a behavioral decoder that predicts the cleaned bytes, and a
// monitor compares every output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_dvb_control_code_stripper_unit_tb;

    import u8dcs_pkg::*;

    localparam int TARGET_ITEMS   = 410;
    localparam int TAIL_ITEMS     = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_REPORTS    = 10;

    // One input byte with its string-start flag.
    typedef struct {
        logic [7:0] value;
        logic       first;
    } text_byte_t;

    // One cleaned output byte or end marker.
    typedef struct {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       end_of_string;
        logic       last_of_run;
    } clean_byte_t;

    // Kinds of characters that the random string generator produces.
    typedef enum int {
        CH_ASCII,
        CH_MULTI,
        CH_CONTROL,
        CH_BROKEN,
        CH_NOISE
    } char_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    u8dcs_in_if  in_ch ();
    u8dcs_out_if out_ch ();

    utf8_dvb_control_code_stripper_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #2 clk = ~clk;

    text_byte_t  string_bytes_q[$];
    clean_byte_t clean_bytes_q[$];
    clean_byte_t step_bytes_q[$];

    // Decoder state of the predictor.
    logic [7:0]        seq_bytes [HOLD_DEPTH];
    logic [CNT_W-1:0]  seq_count;
    logic [CNT_W-1:0]  seq_need;
    logic [CODE_W-1:0] seq_code;

    int   bytes_total;
    int   bytes_taken;
    int   mismatches;
    int   send_gap;
    int   stall_left;
    int   idle_cycles;
    logic in_taken;
    logic calm_tail;
    text_byte_t next_byte;

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] value, input logic first);
        text_byte_t tb_byte;
        tb_byte.value = value;
        tb_byte.first = first;
        string_bytes_q = {string_bytes_q, tb_byte};
    endtask

    // Appends one string: optional selector, a few characters, usually a terminator.
    task automatic queue_random_string();
        char_kind_t  kind;
        int          nchars;
        int          len;
        int          count;
        int          pick;
        logic [31:0] cp;
        logic [31:0] rest;
        logic [7:0]  pfx;
        logic [7:0]  enc [6];
        logic        head;
        head = 1'b1;
        if ($urandom_range(0, 1) == 1)
        begin
            add_byte(SELECTOR_BYTE, 1'b1);
            head = 1'b0;
        end
        nchars = $urandom_range(1, 8);
        for (int i = 0; i < nchars; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 5)
                kind = CH_ASCII;
            else if (pick < 13)
                kind = CH_MULTI;
            else if (pick < 16)
                kind = CH_CONTROL;
            else if (pick < 18)
                kind = CH_BROKEN;
            else
                kind = CH_NOISE;

            // Pick a code point and the length it is encoded in.
            len = 1;
            cp  = 32'($urandom_range(1, 127));
            if (kind == CH_MULTI || kind == CH_BROKEN)
            begin
                len = $urandom_range(2, 6);
                cp  = $urandom & ((32'd1 << (5 * len + 1)) - 32'd1);
            end
            else if (kind == CH_CONTROL)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6) : 3;
                case ($urandom_range(0, 2))
                    0: cp = 32'(CODE_EMPH_ON);
                    1: cp = 32'(CODE_EMPH_OFF);
                    default: cp = 32'(CODE_NEWLINE);
                endcase
            end

            // Encode; overlong forms come out naturally for the longer lengths.
            if (len == 1)
            begin
                enc[0] = cp[7:0];
            end
            else
            begin
                rest = cp;
                for (int j = len - 1; j >= 1; j--)
                begin
                    enc[j] = CONT_TAG | {2'b00, rest[5:0]};
                    rest   = rest >> 6;
                end
                pfx    = 8'hFF << (8 - len);
                enc[0] = pfx | rest[7:0];
            end

            count = (kind == CH_BROKEN) ? $urandom_range(1, len - 1) : len;
            if (kind == CH_NOISE)
            begin
                add_byte(8'($urandom_range(0, 255)),
                         head | ($urandom_range(0, 5) == 0));
                head = 1'b0;
            end
            else
            begin
                for (int j = 0; j < count; j++)
                begin
                    add_byte(enc[j], head);
                    head = 1'b0;
                end
            end
        end
        if ($urandom_range(0, 7) != 0)
            add_byte(8'h00, head);
    endtask

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic push_result(input logic [7:0] value, input logic present,
                               input logic eos);
        clean_byte_t res;
        res.out_byte      = value;
        res.byte_present  = present;
        res.end_of_string = eos;
        res.last_of_run   = 1'b0;
        step_bytes_q = {step_bytes_q, res};
    endtask

    task automatic clear_sequence();
        seq_count = '0;
        seq_need  = '0;
        seq_code  = '0;
    endtask

    task automatic flush_sequence();
        for (int i = 0; i < seq_count && i < HOLD_DEPTH; i++)
            push_result(seq_bytes[i], 1'b1, 1'b0);
    endtask

    // A byte seen with no sequence pending: plain byte, terminator or lead byte.
    task automatic start_character(input logic [7:0] c);
        logic [CNT_W-1:0] need;
        logic [7:0]       mask;
        need = '0;
        mask = '0;
        casez (c)
            8'b110?????: begin need = 3'd1; mask = 8'h1F; end
            8'b1110????: begin need = 3'd2; mask = 8'h0F; end
            8'b11110???: begin need = 3'd3; mask = 8'h07; end
            8'b111110??: begin need = 3'd4; mask = 8'h03; end
            8'b1111110?: begin need = 3'd5; mask = 8'h01; end
            default:     begin need = '0;   mask = '0;    end
        endcase
        if (c == 8'h00)
        begin
            push_result(8'h00, 1'b0, 1'b1);
        end
        else if (c < ASCII_LIMIT || need == 0 || need > HOLD_DEPTH)
        begin
            push_result(c, 1'b1, 1'b0);
        end
        else
        begin
            seq_bytes[0] = c;
            seq_count    = 3'd1;
            seq_need     = need;
            seq_code     = CODE_W'(c & mask);
        end
    endtask

    // Works out the cleaned bytes that one accepted input byte causes.
    task automatic strip_control_codes(input logic [7:0] c, input logic first);
        clean_byte_t tail;
        step_bytes_q.delete();
        if (first)
            clear_sequence();
        if (!(first && c == SELECTOR_BYTE))
        begin
            if (seq_need == 0)
            begin
                start_character(c);
            end
            else if ((c & CONT_MASK) == CONT_TAG)
            begin
                seq_code = {seq_code[CODE_W-7:0], c[5:0]};
                seq_need = seq_need - 3'd1;
                if (seq_need != 0)
                begin
                    if (seq_count < HOLD_DEPTH)
                    begin
                        seq_bytes[seq_count] = c;
                        seq_count            = seq_count + 3'd1;
                    end
                end
                else
                begin
                    // Emphasis codes vanish, the newline code becomes one byte.
                    if (seq_code == CODE_NEWLINE)
                    begin
                        push_result(NEWLINE_BYTE, 1'b1, 1'b0);
                    end
                    else if (seq_code != CODE_EMPH_ON && seq_code != CODE_EMPH_OFF)
                    begin
                        flush_sequence();
                        push_result(c, 1'b1, 1'b0);
                    end
                    clear_sequence();
                end
            end
            else
            begin
                // Malformed: the held bytes go out alone, then this byte starts over.
                flush_sequence();
                clear_sequence();
                start_character(c);
            end
        end
        if (step_bytes_q.size() > 0)
        begin
            tail             = step_bytes_q[step_bytes_q.size() - 1];
            tail.last_of_run = 1'b1;
            step_bytes_q[step_bytes_q.size() - 1] = tail;
        end
        clean_bytes_q = {clean_bytes_q, step_bytes_q};
        step_bytes_q.delete();
    endtask

    task automatic report_mismatch(input string what, input clean_byte_t want,
                                   input clean_byte_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected byte=%02h present=%b end=%b last=%b, got byte=%02h present=%b end=%b last=%b",
                     $realtime, what, want.out_byte, want.byte_present, want.end_of_string,
                     want.last_of_run, got.out_byte, got.byte_present, got.end_of_string,
                     got.last_of_run);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        clean_byte_t got;
        clean_byte_t want;
        in_taken  = rst_n && in_ch.valid && in_ch.ready;
        calm_tail = string_bytes_q.size() < TAIL_ITEMS;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.out_byte      = out_ch.out_byte;
            got.byte_present  = out_ch.byte_present;
            got.end_of_string = out_ch.end_of_string;
            got.last_of_run   = out_ch.last_of_run;
            if (clean_bytes_q.size() == 0)
            begin
                want = '{default: 'x};
                report_mismatch("unexpected output", want, got);
            end
            else
            begin
                want = clean_bytes_q.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_present !== want.byte_present ||
                    got.end_of_string !== want.end_of_string ||
                    got.last_of_run !== want.last_of_run)
                    report_mismatch("output mismatch", want, got);
            end
        end
        if (in_taken)
        begin
            strip_control_codes(in_ch.in_byte, in_ch.first_of_string);
            bytes_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: present the next byte at the falling edge, with idle bursts.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (string_bytes_q.size() == 0)
            begin
                in_ch.valid <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 6);
                in_ch.valid <= 1'b0;
            end
            else
            begin
                next_byte = string_bytes_q.pop_front();
                in_ch.in_byte         <= next_byte.value;
                in_ch.first_of_string <= next_byte.first;
                in_ch.valid           <= 1'b1;
            end
        end
    end

    // Output back-pressure in random bursts.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d outputs outstanding",
                     $realtime, clean_bytes_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        in_ch.valid           = 1'b0;
        in_ch.in_byte         = 8'h00;
        in_ch.first_of_string = 1'b0;
        out_ch.ready          = 1'b0;
        bytes_taken           = 0;
        mismatches            = 0;
        send_gap              = 0;
        stall_left            = 0;
        idle_cycles           = 0;
        in_taken              = 1'b0;
        calm_tail             = 1'b0;
        clear_sequence();

        // Selector at the head of a string is dropped.
        add_byte(SELECTOR_BYTE, 1'b1);
        // Emphasis-on code vanishes, newline code becomes a line feed.
        add_byte(8'hEE, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'h86, 1'b0);
        add_byte(8'hEE, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'h8A, 1'b0);
        // Longest legal sequence passes whole.
        add_byte(8'hFD, 1'b0);
        for (int i = 0; i < 5; i++)
            add_byte(8'hBF, 1'b0);
        // Five held bytes broken by an invalid lead: six results from one byte.
        add_byte(8'hFC, 1'b0);
        for (int i = 0; i < 4; i++)
            add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0);
        // Terminator inside a sequence.
        add_byte(8'hE2, 1'b0); add_byte(8'h00, 1'b0);
        // A new string discards a pending sequence.
        add_byte(8'hC3, 1'b0); add_byte(SELECTOR_BYTE, 1'b1);
        // Stray continuation byte, then a selector not at the head of a string passes.
        add_byte(8'h80, 1'b0); add_byte(8'hFE, 1'b0);
        add_byte(SELECTOR_BYTE, 1'b0); add_byte(8'h7F, 1'b0);

        // Random strings fill the run up to the target byte count.
        while (string_bytes_q.size() < TARGET_ITEMS)
            queue_random_string();
        bytes_total = string_bytes_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < bytes_total)
            @(negedge clk);
        while (clean_bytes_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
